// ===== rtl/wsq_pkg.sv =====
`timescale 1ns / 1ps

package wsq_pkg;

  // Defaults for the top-level parameters.
  localparam int SlotCountDef = 8;
  localparam int RingDepthDef = 16;
  localparam int PageLimitDef = 768;
  localparam int EventBitsDef = 64;

  // Size limits and page arithmetic for create.
  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 768;
  localparam int PageMask   = 'hFFF;
  localparam int PageShift  = 12;
  localparam int PixelShift = 2;

  // Operation codes.
  localparam logic [2:0] OpCreate  = 3'd0;
  localparam logic [2:0] OpPresent = 3'd1;
  localparam logic [2:0] OpClose   = 3'd2;
  localparam logic [2:0] OpPoll    = 3'd3;
  localparam logic [2:0] OpSend    = 3'd4;
  localparam logic [2:0] OpInfo    = 3'd5;
  localparam logic [2:0] OpCleanup = 3'd6;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic [63:0] event_in;
    logic [9:0]  req_height;
    logic [10:0] req_width;
    logic [15:0] requester_pid;
    logic [3:0]  handle;
    logic [2:0]  operation;
  } in_item_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic [9:0]  pages_used;
    logic        info_dirty;
    logic [9:0]  info_height;
    logic [10:0] info_width;
    logic [15:0] info_owner;
    logic        info_active;
    logic [63:0] event_out;
    logic [3:0]  slot_out;
    logic        ok;
  } res_t;

  localparam int InItemW   = $bits(in_item_t);
  localparam int InTdataW  = ((InItemW + 7) / 8) * 8;
  localparam int ResW      = $bits(res_t);
  localparam int OutTdataW = ((ResW + 7) / 8) * 8;

  // Fixed part of one slot entry.
  typedef struct packed {
    logic [15:0] owner;
    logic [10:0] width;
    logic [9:0]  height;
    logic        dirty;
    logic [9:0]  pages;
  } slot_info_t;

  // Commands from the controller to the slot table.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic act_set;
    logic act_clr;
  } tbl_ctl_t;

endpackage

// ===== rtl/wsq_slot_table.sv =====
`timescale 1ns / 1ps

// Slot entries live in a synchronous memory; the in-use bits are flip-flops so
// that a free slot can be found at once and an unused entry reads as zero.
module wsq_slot_table #(
  parameter int SLOT_COUNT = wsq_pkg::SlotCountDef,
  parameter int RING_DEPTH = wsq_pkg::RingDepthDef,
  localparam int SLOT_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
  localparam int PTR_W     = $clog2(RING_DEPTH),
  localparam int CNT_W     = $clog2(RING_DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wsq_pkg::tbl_ctl_t          ctl_i,
  input  logic [SLOT_W-1:0]          rd_idx_i,
  input  logic [SLOT_W-1:0]          wr_idx_i,
  input  wsq_pkg::slot_info_t        wr_info_i,
  input  logic [PTR_W-1:0]           wr_head_i,
  input  logic [PTR_W-1:0]           wr_tail_i,
  input  logic [CNT_W-1:0]           wr_cnt_i,
  output logic                       rd_active_o,
  output wsq_pkg::slot_info_t        rd_info_o,
  output logic [PTR_W-1:0]           rd_head_o,
  output logic [PTR_W-1:0]           rd_tail_o,
  output logic [CNT_W-1:0]           rd_cnt_o,
  output logic [SLOT_COUNT-1:0]      active_o,
  output logic                       free_found_o,
  output logic [SLOT_W-1:0]          free_idx_o
);

  localparam int InfoW  = $bits(wsq_pkg::slot_info_t);
  localparam int EntryW = InfoW + 2 * PTR_W + CNT_W;

  logic [EntryW-1:0]     mem_q [SLOT_COUNT];
  logic [EntryW-1:0]     rd_data_q;
  logic                  rd_act_q;
  logic [SLOT_COUNT-1:0] active_q;
  logic [EntryW-1:0]     rd_view;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_idx_i] <= {wr_info_i, wr_head_i, wr_tail_i, wr_cnt_i};
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      rd_act_q <= 1'b0;
    end else begin
      if (ctl_i.act_set) begin
        active_q[wr_idx_i] <= 1'b1;
      end else if (ctl_i.act_clr) begin
        active_q[wr_idx_i] <= 1'b0;
      end
      if (ctl_i.rd_en) begin
        rd_act_q <= active_q[rd_idx_i];
      end
    end
  end

  // A slot that is not in use reads as zero.
  assign rd_view     = rd_act_q ? rd_data_q : '0;
  assign rd_active_o = rd_act_q;
  assign rd_info_o   = rd_view[EntryW-1 -: InfoW];
  assign rd_head_o   = rd_view[2*PTR_W+CNT_W-1 -: PTR_W];
  assign rd_tail_o   = rd_view[PTR_W+CNT_W-1 -: PTR_W];
  assign rd_cnt_o    = rd_view[CNT_W-1:0];
  assign active_o    = active_q;

  // Lowest free slot.
  always_comb begin
    free_found_o = 1'b0;
    free_idx_o   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found_o = 1'b1;
        free_idx_o   = SLOT_W'(i);
      end
    end
  end

endmodule

// ===== rtl/window_slot_event_queue_table_unit.sv =====
`timescale 1ns / 1ps
// Request paths through the controller: create through S_MUL and S_CRT; present, close,
// send, info and poll through S_RD and S_EXE, then S_EVT for a poll that returns an event;
// cleanup through S_CRD and S_CCK for each slot in turn; a slot request with a handle out
// of range or the unused operation code goes straight to S_DONE, where every request ends.
// One request at a time: the next is taken once the result is in the output register.
// Reset (rst_ni low, asynchronous) frees every slot and empties every event ring at once.
module window_slot_event_queue_table_unit #(
  parameter int SLOT_COUNT = wsq_pkg::SlotCountDef,
  parameter int RING_DEPTH = wsq_pkg::RingDepthDef,
  parameter int PAGE_LIMIT = wsq_pkg::PageLimitDef,
  parameter int EVENT_BITS = wsq_pkg::EventBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0 up: operation, handle, requester_pid, req_width, req_height,
  // event_in, zero fill.
  input  logic [wsq_pkg::InTdataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0 up: ok, slot_out, event_out, info_active, info_owner, info_width,
  // info_height, info_dirty, pages_used, zero fill.
  output logic [wsq_pkg::OutTdataW-1:0] m_axis_tdata
);

  localparam int SLOT_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PTR_W    = $clog2(RING_DEPTH);
  localparam int CNT_W    = $clog2(RING_DEPTH + 1);
  localparam int EV_DEPTH = SLOT_COUNT * RING_DEPTH;
  localparam int EA_W     = $clog2(EV_DEPTH);

  // Controller states.
  localparam logic [3:0] S_IDLE = 4'd0;  // waiting for a request
  localparam logic [3:0] S_MUL  = 4'd1;  // create: width times height
  localparam logic [3:0] S_CRT  = 4'd2;  // create: checks and table write
  localparam logic [3:0] S_RD   = 4'd3;  // slot entry read issued
  localparam logic [3:0] S_EXE  = 4'd4;  // read data back, modify and write
  localparam logic [3:0] S_EVT  = 4'd5;  // poll: event memory data back
  localparam logic [3:0] S_CRD  = 4'd6;  // cleanup: read one slot
  localparam logic [3:0] S_CCK  = 4'd7;  // cleanup: check owner, free
  localparam logic [3:0] S_DONE = 4'd8;  // hand the result to the output register

  wsq_pkg::in_item_t   in_item;
  logic                in_accept;
  logic                in_hv;

  logic [3:0]          state_q, state_d;
  logic [2:0]          op_q;
  logic [3:0]          handle_q;
  logic [15:0]         pid_q;
  logic [10:0]         w_q;
  logic [9:0]          h_q;
  logic [EVENT_BITS-1:0] ev_q;
  logic [20:0]         prod_q;
  logic [SLOT_W-1:0]   scan_q, scan_d;
  wsq_pkg::res_t       res_q, res_d;
  wsq_pkg::res_t       out_q;
  logic                m_valid_q;
  logic                out_free;

  // Slot table interface.
  wsq_pkg::tbl_ctl_t   ctl;
  logic [SLOT_W-1:0]   rd_idx, wr_idx, hidx;
  wsq_pkg::slot_info_t wr_info, rd_info;
  logic [PTR_W-1:0]    wr_head, wr_tail, rd_head, rd_tail;
  logic [CNT_W-1:0]    wr_cnt, rd_cnt;
  logic                rd_active;
  logic [SLOT_COUNT-1:0] tbl_active;
  logic                free_found;
  logic [SLOT_W-1:0]   free_idx;

  // Event memory: one ring of RING_DEPTH entries per slot, never cleared; a poll only
  // reaches entries that a send has written since the ring was last empty.
  logic [EVENT_BITS-1:0] ev_mem_q [EV_DEPTH];
  logic [EVENT_BITS-1:0] ev_rdata_q;
  logic                  ev_we, ev_re;
  logic [EA_W-1:0]       ev_addr;

  // Create arithmetic.
  logic                dims_ok;
  logic [23:0]         page_sum;
  logic [11:0]         pages;
  logic                owned;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [EA_W-1:0] ev_index(input logic [SLOT_W-1:0] s,
                                               input logic [PTR_W-1:0] p);
    ev_index = EA_W'(EA_W'(s) * EA_W'(RING_DEPTH)) + EA_W'(p);
  endfunction

  assign in_item       = s_axis_tdata[wsq_pkg::InItemW-1:0];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_hv         = {1'b0, in_item.handle} < 5'(SLOT_COUNT);
  assign hidx          = handle_q[SLOT_W-1:0];
  assign out_free      = !m_valid_q || m_axis_tready;

  assign dims_ok  = (w_q != '0) && (h_q != '0) &&
                    (w_q <= 11'(wsq_pkg::MaxWidth)) && (h_q <= 10'(wsq_pkg::MaxHeight));
  // Pages are ceil(width * height * 4 / 4096).
  assign page_sum = {1'b0, prod_q, wsq_pkg::PixelShift'(0)} + 24'(wsq_pkg::PageMask);
  assign pages    = page_sum[23:wsq_pkg::PageShift];
  assign owned    = rd_active && (rd_info.owner == pid_q);

  wsq_slot_table #(
    .SLOT_COUNT (SLOT_COUNT),
    .RING_DEPTH (RING_DEPTH)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .rd_idx_i     (rd_idx),
    .wr_idx_i     (wr_idx),
    .wr_info_i    (wr_info),
    .wr_head_i    (wr_head),
    .wr_tail_i    (wr_tail),
    .wr_cnt_i     (wr_cnt),
    .rd_active_o  (rd_active),
    .rd_info_o    (rd_info),
    .rd_head_o    (rd_head),
    .rd_tail_o    (rd_tail),
    .rd_cnt_o     (rd_cnt),
    .active_o     (tbl_active),
    .free_found_o (free_found),
    .free_idx_o   (free_idx)
  );

  // The controller reads a slot entry, works on it in the cycle its data returns and
  // writes it back. Only one request is in flight, so a write always lands before the
  // next read of the same entry and no forwarding is needed.
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    scan_d  = scan_q;
    ctl     = '0;
    rd_idx  = hidx;
    wr_idx  = hidx;
    wr_info = rd_info;
    wr_head = rd_head;
    wr_tail = rd_tail;
    wr_cnt  = rd_cnt;
    ev_we   = 1'b0;
    ev_re   = 1'b0;
    ev_addr = ev_index(hidx, rd_head);
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          res_d  = '0;
          scan_d = '0;
          case (in_item.operation)
            wsq_pkg::OpCreate:  state_d = S_MUL;
            wsq_pkg::OpPresent,
            wsq_pkg::OpClose,
            wsq_pkg::OpPoll,
            wsq_pkg::OpSend,
            wsq_pkg::OpInfo:    state_d = in_hv ? S_RD : S_DONE;
            wsq_pkg::OpCleanup: state_d = S_CRD;
            default:            state_d = S_DONE;
          endcase
        end
      end
      S_MUL: begin
        state_d = S_CRT;
      end
      S_CRT: begin
        if (dims_ok && free_found && (pages <= 12'(PAGE_LIMIT))) begin
          ctl.wr_en      = 1'b1;
          ctl.act_set    = 1'b1;
          wr_idx         = free_idx;
          wr_info.owner  = pid_q;
          wr_info.width  = w_q;
          wr_info.height = h_q;
          wr_info.dirty  = 1'b0;
          wr_info.pages  = pages[9:0];
          wr_head        = '0;
          wr_tail        = '0;
          wr_cnt         = '0;
          res_d.ok         = 1'b1;
          res_d.slot_out   = 4'(free_idx);
          res_d.pages_used = pages[9:0];
        end
        state_d = S_DONE;
      end
      S_RD: begin
        ctl.rd_en = 1'b1;
        state_d   = S_EXE;
      end
      S_EXE: begin
        state_d = S_DONE;
        case (op_q)
          wsq_pkg::OpPresent: begin
            if (owned) begin
              ctl.wr_en     = 1'b1;
              wr_info.dirty = 1'b1;
              res_d.ok      = 1'b1;
            end
          end
          wsq_pkg::OpClose: begin
            if (owned) begin
              ctl.act_clr = 1'b1;
              res_d.ok    = 1'b1;
            end
          end
          wsq_pkg::OpPoll: begin
            if (owned && (rd_cnt != '0)) begin
              ev_re     = 1'b1;
              ev_addr   = ev_index(hidx, rd_tail);
              ctl.wr_en = 1'b1;
              wr_tail   = ptr_inc(rd_tail);
              wr_cnt    = rd_cnt - 1'b1;
              res_d.ok  = 1'b1;
              state_d   = S_EVT;
            end
          end
          wsq_pkg::OpSend: begin
            if (rd_active) begin
              // A full ring drops its oldest event; the count then stays at full.
              if (rd_cnt == CNT_W'(RING_DEPTH)) begin
                wr_tail = ptr_inc(rd_tail);
              end else begin
                wr_cnt = rd_cnt + 1'b1;
              end
              ev_we     = 1'b1;
              ev_addr   = ev_index(hidx, rd_head);
              wr_head   = ptr_inc(rd_head);
              ctl.wr_en = 1'b1;
              res_d.ok  = 1'b1;
            end
          end
          wsq_pkg::OpInfo: begin
            if (rd_active) begin
              res_d.ok          = 1'b1;
              res_d.info_active = 1'b1;
              res_d.info_owner  = rd_info.owner;
              res_d.info_width  = rd_info.width;
              res_d.info_height = rd_info.height;
              res_d.info_dirty  = rd_info.dirty;
            end
          end
          default: begin
          end
        endcase
      end
      S_EVT: begin
        res_d.event_out = 64'(ev_rdata_q);
        state_d         = S_DONE;
      end
      S_CRD: begin
        ctl.rd_en = 1'b1;
        rd_idx    = scan_q;
        state_d   = S_CCK;
      end
      S_CCK: begin
        wr_idx = scan_q;
        if (owned) begin
          ctl.act_clr = 1'b1;
          res_d.ok    = 1'b1;
        end
        if (scan_q == SLOT_W'(SLOT_COUNT - 1)) begin
          state_d = S_DONE;
        end else begin
          scan_d  = scan_q + 1'b1;
          state_d = S_CRD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_DONE) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Request fields, result and scan index are payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= in_item.operation;
      handle_q <= in_item.handle;
      pid_q    <= in_item.requester_pid;
      w_q      <= in_item.req_width;
      h_q      <= in_item.req_height;
      ev_q     <= in_item.event_in[EVENT_BITS-1:0];
    end
    prod_q <= 21'(w_q) * 21'(h_q);
    res_q  <= res_d;
    scan_q <= scan_d;
    if ((state_q == S_DONE) && out_free) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_we) begin
      ev_mem_q[ev_addr] <= ev_q;
    end
    if (ev_re) begin
      ev_rdata_q <= ev_mem_q[ev_addr];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = wsq_pkg::OutTdataW'(out_q);

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_DONE))
    else $error("result shown without a finished request");

  a_ring_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXE) |-> (rd_cnt <= CNT_W'(RING_DEPTH)))
    else $error("event ring count above its depth");

  a_create_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.act_set |-> !tbl_active[wr_idx])
    else $error("create took a slot already in use");
`endif

endmodule

// ===== tb/window_slot_event_queue_table_unit_tb.sv =====
`timescale 1ns / 1ps

module window_slot_event_queue_table_unit_tb;

  localparam int Slots     = wsq_pkg::SlotCountDef;
  localparam int Ring      = wsq_pkg::RingDepthDef;
  localparam int PageLimit = wsq_pkg::PageLimitDef;
  localparam int EventBits = wsq_pkg::EventBitsDef;
  localparam int InTdataW  = wsq_pkg::InTdataW;
  localparam int OutTdataW = wsq_pkg::OutTdataW;
  localparam int InItemW   = wsq_pkg::InItemW;
  localparam int ResW      = wsq_pkg::ResW;

  // Two independent copies of the slot table: one steers the stimulus, one checks results.
  localparam int GenView   = 0;
  localparam int CheckView = 1;

  localparam logic [2:0] OpUnused = 3'd7;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  always #4 clk_i = ~clk_i;

  window_slot_event_queue_table_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow slot table, one copy per view.
  logic        tbl_active [2][Slots];
  logic [15:0] tbl_owner  [2][Slots];
  logic [10:0] tbl_width  [2][Slots];
  logic [9:0]  tbl_height [2][Slots];
  logic        tbl_dirty  [2][Slots];
  logic [9:0]  tbl_pages  [2][Slots];
  int unsigned ring_wr    [2][Slots];
  int unsigned ring_rd    [2][Slots];
  int unsigned ring_fill  [2][Slots];
  logic [63:0] ring_mem   [2][Slots*Ring];

  wsq_pkg::in_item_t pending_requests [$];
  wsq_pkg::res_t     expected_results [$];

  int unsigned op_count [8];
  int unsigned ok_count [8];
  int unsigned overflow_count;
  int unsigned mismatch_count;
  int unsigned results_seen;
  int unsigned requests_taken;

  logic [15:0] pid_pool [4];

  function automatic void release_slot(int c, int s);
    tbl_active[c][s] = 1'b0;
    tbl_owner[c][s]  = '0;
    tbl_width[c][s]  = '0;
    tbl_height[c][s] = '0;
    tbl_dirty[c][s]  = 1'b0;
    tbl_pages[c][s]  = '0;
    ring_wr[c][s]    = 0;
    ring_rd[c][s]    = 0;
    ring_fill[c][s]  = 0;
  endfunction

  function automatic void clear_table(int c);
    int i;
    for (i = 0; i < Slots; i++) release_slot(c, i);
    for (i = 0; i < Slots * Ring; i++) ring_mem[c][i] = '0;
  endfunction

  function automatic logic owns_slot(int c, int s, logic [15:0] pid);
    return tbl_active[c][s] && (tbl_owner[c][s] == pid);
  endfunction

  // Applies one request to the given view and returns the result it must produce.
  function automatic wsq_pkg::res_t table_step(int c, wsq_pkg::in_item_t it);
    wsq_pkg::res_t r;
    int            s;
    int            i;
    int            hs;
    int unsigned   w;
    int unsigned   h;
    int unsigned   pages;
    logic          hv;
    logic [63:0]   ev_mask;
    r       = '0;
    w       = 32'(it.req_width);
    h       = 32'(it.req_height);
    hs      = 32'(it.handle);
    hv      = (hs < Slots);
    ev_mask = {64{1'b1}} >> (64 - EventBits);
    case (it.operation)
      wsq_pkg::OpCreate: begin
        if (w != 0 && h != 0 && w <= wsq_pkg::MaxWidth && h <= wsq_pkg::MaxHeight) begin
          s = -1;
          for (i = Slots - 1; i >= 0; i--) if (!tbl_active[c][i]) s = i;
          pages = (((w * h) << wsq_pkg::PixelShift) + wsq_pkg::PageMask) >> wsq_pkg::PageShift;
          if (s >= 0 && pages <= PageLimit) begin
            release_slot(c, s);
            tbl_active[c][s] = 1'b1;
            tbl_owner[c][s]  = it.requester_pid;
            tbl_width[c][s]  = w[10:0];
            tbl_height[c][s] = h[9:0];
            tbl_pages[c][s]  = pages[9:0];
            r.ok         = 1'b1;
            r.slot_out   = s[3:0];
            r.pages_used = pages[9:0];
          end
        end
      end
      wsq_pkg::OpPresent: begin
        if (hv && owns_slot(c, hs, it.requester_pid)) begin
          tbl_dirty[c][hs] = 1'b1;
          r.ok = 1'b1;
        end
      end
      wsq_pkg::OpClose: begin
        if (hv && owns_slot(c, hs, it.requester_pid)) begin
          release_slot(c, hs);
          r.ok = 1'b1;
        end
      end
      wsq_pkg::OpPoll: begin
        if (hv && owns_slot(c, hs, it.requester_pid) && ring_fill[c][hs] != 0) begin
          r.ok        = 1'b1;
          r.event_out = ring_mem[c][hs * Ring + ring_rd[c][hs]] & ev_mask;
          ring_rd[c][hs]   = (ring_rd[c][hs] + 1) % Ring;
          ring_fill[c][hs] = ring_fill[c][hs] - 1;
        end
      end
      wsq_pkg::OpSend: begin
        if (hv && tbl_active[c][hs]) begin
          // A full ring loses its oldest event before the new one goes in.
          if (ring_fill[c][hs] >= Ring) begin
            ring_rd[c][hs]   = (ring_rd[c][hs] + 1) % Ring;
            ring_fill[c][hs] = ring_fill[c][hs] - 1;
            if (c == CheckView) overflow_count++;
          end
          ring_mem[c][hs * Ring + ring_wr[c][hs]] = it.event_in & ev_mask;
          ring_wr[c][hs]   = (ring_wr[c][hs] + 1) % Ring;
          ring_fill[c][hs] = ring_fill[c][hs] + 1;
          r.ok = 1'b1;
        end
      end
      wsq_pkg::OpInfo: begin
        if (hv && tbl_active[c][hs]) begin
          r.ok          = 1'b1;
          r.info_active = 1'b1;
          r.info_owner  = tbl_owner[c][hs];
          r.info_width  = tbl_width[c][hs];
          r.info_height = tbl_height[c][hs];
          r.info_dirty  = tbl_dirty[c][hs];
        end
      end
      wsq_pkg::OpCleanup: begin
        for (i = 0; i < Slots; i++) begin
          if (owns_slot(c, i, it.requester_pid)) begin
            release_slot(c, i);
            r.ok = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (c == CheckView) begin
      op_count[it.operation]++;
      if (r.ok) ok_count[it.operation]++;
    end
    return r;
  endfunction

  // Queues one request and advances the stimulus view so later choices see its effect.
  function automatic void queue_request(logic [2:0] op, logic [3:0] handle, logic [15:0] pid,
                                        logic [10:0] w, logic [9:0] h, logic [63:0] ev);
    wsq_pkg::in_item_t it;
    it.operation     = op;
    it.handle        = handle;
    it.requester_pid = pid;
    it.req_width     = w;
    it.req_height    = h;
    it.event_in      = ev;
    pending_requests.push_back(it);
    void'(table_step(GenView, it));
  endfunction

  function automatic logic [63:0] random_event();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [15:0] pick_pid();
    if ($urandom_range(0, 9) == 0) return 16'($urandom());
    return pid_pool[$urandom_range(0, 3)];
  endfunction

  function automatic int pick_active_slot();
    int found [$];
    int i;
    for (i = 0; i < Slots; i++) if (tbl_active[GenView][i]) found.push_back(i);
    if (found.size() == 0) return -1;
    return found[$urandom_range(0, found.size() - 1)];
  endfunction

  function automatic logic table_has_room();
    int i;
    for (i = 0; i < Slots; i++) if (!tbl_active[GenView][i]) return 1'b1;
    return 1'b0;
  endfunction

  // Mostly small windows, now and then the largest legal one or an illegal size.
  function automatic void queue_create(logic [15:0] pid);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0)
      queue_request(wsq_pkg::OpCreate, 4'($urandom()), pid, 11'(wsq_pkg::MaxWidth),
                    10'(wsq_pkg::MaxHeight), random_event());
    else if (sel == 1)
      case ($urandom_range(0, 3))
        0: queue_request(wsq_pkg::OpCreate, 4'($urandom()), pid, 11'd0,
                         10'($urandom_range(1, 768)), random_event());
        1: queue_request(wsq_pkg::OpCreate, 4'($urandom()), pid,
                         11'($urandom_range(1, 1024)), 10'd0, random_event());
        2: queue_request(wsq_pkg::OpCreate, 4'($urandom()), pid,
                         11'($urandom_range(1025, 2047)), 10'($urandom_range(1, 768)),
                         random_event());
        default: queue_request(wsq_pkg::OpCreate, 4'($urandom()), pid,
                               11'($urandom_range(1, 1024)), 10'($urandom_range(769, 1023)),
                               random_event());
      endcase
    else
      queue_request(wsq_pkg::OpCreate, 4'($urandom()), pid, 11'($urandom_range(1, 96)),
                    10'($urandom_range(1, 96)), random_event());
  endfunction

  // A run of sends into one live slot, then polls, mostly by its owner, sometimes past empty.
  function automatic void queue_event_run(int s);
    int          n;
    int          m;
    int          i;
    logic [15:0] owner;
    owner = tbl_owner[GenView][s];
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 24) : $urandom_range(1, 8);
    for (i = 0; i < n; i++)
      queue_request(wsq_pkg::OpSend, 4'(s), pick_pid(), 11'($urandom()), 10'($urandom()),
                    random_event());
    m = $urandom_range(0, n + 2);
    for (i = 0; i < m; i++) begin
      if ($urandom_range(0, 7) == 0)
        queue_request(wsq_pkg::OpPoll, 4'(s), pick_pid(), 11'($urandom()), 10'($urandom()),
                      random_event());
      else
        queue_request(wsq_pkg::OpPoll, 4'(s), owner, 11'($urandom()), 10'($urandom()),
                      random_event());
    end
  endfunction

  function automatic void queue_slot_access(int s);
    logic [15:0] pid;
    int          sel;
    pid = ($urandom_range(0, 4) != 0) ? tbl_owner[GenView][s] : pick_pid();
    sel = $urandom_range(0, 9);
    if (sel < 4)
      queue_request(wsq_pkg::OpPresent, 4'(s), pid, 11'($urandom()), 10'($urandom()),
                    random_event());
    else if (sel < 8)
      queue_request(wsq_pkg::OpInfo, 4'(s), pid, 11'($urandom()), 10'($urandom()),
                    random_event());
    else
      queue_request(wsq_pkg::OpClose, 4'(s), pid, 11'($urandom()), 10'($urandom()),
                    random_event());
  endfunction

  function automatic void queue_random_mix(int unsigned target);
    int kind;
    int s;
    while (pending_requests.size() < target) begin
      kind = $urandom_range(0, 99);
      s    = pick_active_slot();
      if (kind < 15 || (kind < 60 && s < 0)) begin
        queue_create(pick_pid());
      end else if (kind < 40) begin
        queue_event_run(s);
      end else if (kind < 60) begin
        queue_slot_access(s);
      end else if (kind < 67) begin
        if (s >= 0 && $urandom_range(0, 2) != 0)
          queue_request(wsq_pkg::OpCleanup, 4'($urandom()), tbl_owner[GenView][s],
                        11'($urandom()), 10'($urandom()), random_event());
        else
          queue_request(wsq_pkg::OpCleanup, 4'($urandom()), pick_pid(), 11'($urandom()),
                        10'($urandom()), random_event());
      end else if (kind < 71) begin
        // Fill the table, then ask once more so create meets a full table.
        while (table_has_room())
          queue_request(wsq_pkg::OpCreate, 4'($urandom()), pick_pid(),
                        11'($urandom_range(1, 64)), 10'($urandom_range(1, 64)),
                        random_event());
        queue_create(pick_pid());
      end else if (kind < 80) begin
        queue_request($urandom_range(0, 1) ? wsq_pkg::OpInfo : wsq_pkg::OpPresent,
                      4'($urandom()), pick_pid(), 11'($urandom()), 10'($urandom()),
                      random_event());
      end else begin
        queue_request(3'($urandom()), 4'($urandom()), 16'($urandom()), 11'($urandom()),
                      10'($urandom()), random_event());
      end
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Sender: bursts of back-to-back transactions separated by random gaps.
  logic                in_fire = 1'b0;
  int                  burst_left = 0;
  int                  gap_left = 0;
  logic [InTdataW-1:0] drv_word;

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        drv_word = '0;
        drv_word[InItemW-1:0] = pending_requests.pop_front();
        s_axis_tdata  <= drv_word;
        s_axis_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          if ($urandom_range(0, 29) == 0) gap_left = $urandom_range(30, 60);
          else if ($urandom_range(0, 2) == 0) gap_left = 0;
          else gap_left = $urandom_range(1, 12);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: a stall pattern that changes now and then, plus one long hold-off
  // so the result register stays full and the input side has to wait.
  int unsigned rcv_cycle = 0;
  int          rcv_mode = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  logic        rdy_next;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      rcv_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        rdy_next = 1'b0;
      end else if (!hold_done && results_seen >= 200) begin
        hold_done = 1'b1;
        hold_left = 400;
        rdy_next  = 1'b0;
      end else begin
        if (rcv_cycle % 97 == 0) rcv_mode = $urandom_range(0, 3);
        case (rcv_mode)
          0:       rdy_next = 1'b1;
          1:       rdy_next = 1'($urandom_range(0, 1));
          2:       rdy_next = ($urandom_range(0, 7) != 0);
          default: rdy_next = ((rcv_cycle / 3) % 2 == 0);
        endcase
      end
      m_axis_tready <= rdy_next;
    end
  end

  // Monitor: results are checked before this edge's input transaction is predicted,
  // since a result can never belong to a request taken at the same edge.
  wsq_pkg::res_t     mon_got;
  wsq_pkg::res_t     mon_want;
  wsq_pkg::in_item_t mon_taken;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        mon_got = m_axis_tdata[ResW-1:0];
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding", mon_got.event_out,
                          64'd0);
        end else begin
          mon_want = expected_results.pop_front();
          check_field("ok", 64'(mon_got.ok), 64'(mon_want.ok));
          check_field("slot_out", 64'(mon_got.slot_out), 64'(mon_want.slot_out));
          check_field("event_out", mon_got.event_out, mon_want.event_out);
          check_field("info_active", 64'(mon_got.info_active), 64'(mon_want.info_active));
          check_field("info_owner", 64'(mon_got.info_owner), 64'(mon_want.info_owner));
          check_field("info_width", 64'(mon_got.info_width), 64'(mon_want.info_width));
          check_field("info_height", 64'(mon_got.info_height), 64'(mon_want.info_height));
          check_field("info_dirty", 64'(mon_got.info_dirty), 64'(mon_want.info_dirty));
          check_field("pages_used", 64'(mon_got.pages_used), 64'(mon_want.pages_used));
        end
      end
      in_fire = s_axis_tvalid && s_axis_tready;
      if (in_fire) begin
        mon_taken = s_axis_tdata[InItemW-1:0];
        expected_results.push_back(table_step(CheckView, mon_taken));
        requests_taken++;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d results still outstanding.", expected_results.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [15:0] pa;
    logic [15:0] pb;
    clear_table(GenView);
    clear_table(CheckView);
    pid_pool[0] = 16'h0000;
    pid_pool[1] = 16'hFFFF;
    pid_pool[2] = 16'h1234;
    pid_pool[3] = 16'hC3A5;
    pa = pid_pool[0];
    pb = pid_pool[1];

    // Directed part: size limits, ownership, rings, cleanup and the unused code.
    queue_request(wsq_pkg::OpCreate, 4'd9, pa, 11'd1, 10'd1, 64'd0);
    queue_request(wsq_pkg::OpCreate, 4'd0, pb, 11'(wsq_pkg::MaxWidth),
                  10'(wsq_pkg::MaxHeight), 64'd0);
    queue_request(wsq_pkg::OpCreate, 4'd0, pa, 11'd0, 10'd5, 64'd0);
    queue_request(wsq_pkg::OpCreate, 4'd0, pa, 11'd5, 10'd0, 64'd0);
    queue_request(wsq_pkg::OpCreate, 4'd0, pa, 11'(wsq_pkg::MaxWidth + 1),
                  10'(wsq_pkg::MaxHeight), 64'd0);
    queue_request(wsq_pkg::OpCreate, 4'd0, pa, 11'(wsq_pkg::MaxWidth),
                  10'(wsq_pkg::MaxHeight + 1), 64'd0);
    queue_request(wsq_pkg::OpCreate, 4'hF, pa, 11'h7FF, 10'h3FF, {64{1'b1}});
    queue_request(wsq_pkg::OpPresent, 4'd0, pa, 11'd0, 10'd0, 64'd0);
    queue_request(wsq_pkg::OpPresent, 4'd0, pb, 11'd0, 10'd0, 64'd0);
    queue_request(wsq_pkg::OpPresent, 4'hF, pa, 11'd0, 10'd0, 64'd0);
    queue_request(wsq_pkg::OpPresent, 4'(Slots), pa, 11'd0, 10'd0, 64'd0);
    queue_request(wsq_pkg::OpInfo, 4'd0, pb, 11'd0, 10'd0, 64'd0);
    queue_request(wsq_pkg::OpInfo, 4'd5, pa, 11'd0, 10'd0, 64'd0);
    queue_request(wsq_pkg::OpInfo, 4'hF, pa, 11'd0, 10'd0, 64'd0);
    queue_request(wsq_pkg::OpSend, 4'd0, pid_pool[2], 11'd0, 10'd0, {64{1'b1}});
    queue_request(wsq_pkg::OpSend, 4'd0, pb, 11'd0, 10'd0, 64'd0);
    queue_request(wsq_pkg::OpSend, 4'd3, pa, 11'd0, 10'd0, 64'h0123_4567_89AB_CDEF);
    queue_request(wsq_pkg::OpPoll, 4'd0, pb, 11'd0, 10'd0, 64'd0);
    queue_request(wsq_pkg::OpPoll, 4'd0, pa, 11'd0, 10'd0, 64'd0);
    queue_request(wsq_pkg::OpPoll, 4'd0, pa, 11'd0, 10'd0, 64'd0);
    queue_request(wsq_pkg::OpPoll, 4'd0, pa, 11'd0, 10'd0, 64'd0);
    queue_request(wsq_pkg::OpClose, 4'd1, pa, 11'd0, 10'd0, 64'd0);
    queue_request(wsq_pkg::OpClose, 4'd1, pb, 11'd0, 10'd0, 64'd0);
    queue_request(wsq_pkg::OpCleanup, 4'd0, 16'hBEEF, 11'd0, 10'd0, 64'd0);
    queue_request(wsq_pkg::OpCleanup, 4'd0, pa, 11'd0, 10'd0, 64'd0);
    queue_request(OpUnused, 4'hA, 16'($urandom()), 11'($urandom()), 10'($urandom()),
                  random_event());

    queue_random_mix(pending_requests.size() + 900);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Everything handed over, every result back, then room for a stray late result.
    while (pending_requests.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (2 * Slots + 24) @(negedge clk_i);

    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 64'(expected_results.size()), 64'd0);

    $display("Ran %0d transactions: create %0d (%0d ok), poll %0d (%0d ok), %0d ring overflows.",
             requests_taken, op_count[wsq_pkg::OpCreate], ok_count[wsq_pkg::OpCreate],
             op_count[wsq_pkg::OpPoll], ok_count[wsq_pkg::OpPoll], overflow_count);
    $display("Present %0d, close %0d, send %0d, info %0d, cleanup %0d, unused %0d, errors %0d.",
             op_count[wsq_pkg::OpPresent], op_count[wsq_pkg::OpClose],
             op_count[wsq_pkg::OpSend], op_count[wsq_pkg::OpInfo],
             op_count[wsq_pkg::OpCleanup], op_count[OpUnused], mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
